@@ design/hevc_rtp_packetizer_top_defines.svh @@
// Assertion macros for the HEVC RTP packetizer.
`ifndef HEVC_RTP_PACKETIZER_TOP_DEFINES_SVH
`define HEVC_RTP_PACKETIZER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define HRP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hrp_pkg.sv @@
// Shared types and constants for the HEVC RTP packetizer.
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 24;
    localparam int KIND_W  = 6;
    localparam int TS_W    = 32;
    localparam int SSRC_W  = 32;
    localparam int FRAG_W  = 11;
    localparam int SEQ_W   = 16;
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SSRC    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXFRAG = 1'b1;

    localparam logic [FRAG_W-1:0] FRAG_MIN   = 11'd16;
    localparam logic [FRAG_W-1:0] FRAG_RESET = 11'd1385;

    localparam logic [LEN_W-1:0] START_CODE_LEN = 24'd4;
    localparam logic [LEN_W-1:0] POS_FIRST_PAYLOAD = 24'd4;
    localparam logic [LEN_W-1:0] POS_FIRST_FU = 24'd6;

    localparam logic [7:0] RTP_VER_BYTE = 8'h80;
    localparam logic [6:0] RTP_PT       = 7'h60;
    localparam logic [7:0] FU_IND_HI    = 8'h62;
    localparam logic [7:0] FU_IND_LO    = 8'h01;
    localparam logic [1:0] FU_START_BITS = 2'b10;
    localparam logic [1:0] FU_END_BITS   = 2'b01;

    localparam logic [IDX_W-1:0] HDR_LAST_IDX = 4'd11;
    localparam logic [IDX_W-1:0] FU_LAST_IDX  = 4'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        FU_POS_MID   = 2'd0,
        FU_POS_START = 2'd1,
        FU_POS_END   = 2'd2
    } fu_pos_t;

    // One classified input item: what the back end has to send for it.
    typedef struct packed {
        logic              hdr;
        logic              hdr_marker;
        logic              hdr_end;
        logic              fu;
        fu_pos_t           fu_pos;
        logic              data_en;
        logic [DATA_W-1:0] data_byte;
        logic              data_end;
        logic              tail;
        logic              tail_marker;
        logic [KIND_W-1:0] kind;
        logic [TS_W-1:0]   timestamp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_HDR   = 6'b000010,
        PH_FU    = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_THDR  = 6'b010000,
        PH_TFU   = 6'b100000
    } phase_t;

endpackage

@@ design/hrp_front.sv @@
// Front end: accepts NAL bytes, tracks NAL/chunk position, classifies each item.
`timescale 1ns / 1ps

module hrp_front import hrp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte, nal_length, timestamp
    input  logic [S_TUSER_W-1:0] s_tuser,   // nal_kind, frame_end
    input  logic [FRAG_W-1:0]    max_fragment,
    input  fifo_stat_t           fifo_stat,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              frag_reg, frag_next;
    logic [FRAG_W-1:0] fill_reg, fill_next;
    logic              end_open_reg, end_open_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              marker_reg, marker_next;
    logic [TS_W-1:0]   ts_reg, ts_next;

    logic              accept;
    logic [FRAG_W-1:0] mtu;
    logic              first_byte;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W:0]    pos_inc;
    logic              last;
    logic [LEN_W-1:0]  remain;
    logic              chunk_first;
    logic              chunk_open;
    logic [FRAG_W-1:0] fill_cur;
    logic [FRAG_W-1:0] fill_base;
    logic [FRAG_W:0]   fill_inc;
    logic              end_open_cur;
    logic              is_end;
    logic              chunk_ends;
    logic              end_open_new;
    logic              frag_body;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        mtu        = (max_fragment < FRAG_MIN) ? FRAG_MIN : max_fragment;
        first_byte = (pos_reg == '0);
        len_in     = s_tdata[31:8];

        if (first_byte) begin
            len_next    = (len_in == '0) ? {{(LEN_W-1){1'b0}}, 1'b1} : len_in;
            kind_next   = s_tuser[KIND_W-1:0];
            marker_next = s_tuser[KIND_W];
            ts_next     = s_tdata[63:32];
            frag_next   = (len_next > START_CODE_LEN) &&
                          ((len_next - START_CODE_LEN) > {{(LEN_W-FRAG_W){1'b0}}, mtu});
            fill_cur     = '0;
            end_open_cur = 1'b0;
        end else begin
            len_next     = len_reg;
            kind_next    = kind_reg;
            marker_next  = marker_reg;
            ts_next      = ts_reg;
            frag_next    = frag_reg;
            fill_cur     = fill_reg;
            end_open_cur = end_open_reg;
        end

        pos_inc = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
        last    = (pos_inc >= {1'b0, len_next});
        remain  = len_next - pos_reg;

        chunk_first  = (pos_reg == POS_FIRST_FU);
        chunk_open   = chunk_first || (fill_cur >= mtu);
        is_end       = !chunk_first && (remain <= {{(LEN_W-FRAG_W){1'b0}}, mtu});
        fill_base    = chunk_open ? '0 : fill_cur;
        fill_inc     = {1'b0, fill_base} + {{FRAG_W{1'b0}}, 1'b1};
        chunk_ends   = last || (fill_inc >= {1'b0, mtu});
        end_open_new = chunk_open ? is_end : end_open_cur;
        frag_body    = frag_next && (pos_reg >= POS_FIRST_FU);

        push_cmd           = '0;
        push_cmd.kind      = kind_next;
        push_cmd.timestamp = ts_next;
        push_cmd.data_byte = s_tdata[DATA_W-1:0];
        push_cmd.fu_pos    = FU_POS_MID;

        if (!frag_next) begin
            if (len_next <= START_CODE_LEN) begin
                push_cmd.hdr        = last;
                push_cmd.hdr_end    = last;
                push_cmd.hdr_marker = marker_next;
            end else if (pos_reg >= POS_FIRST_PAYLOAD) begin
                push_cmd.hdr        = (pos_reg == POS_FIRST_PAYLOAD);
                push_cmd.hdr_marker = marker_next;
                push_cmd.data_en    = 1'b1;
                push_cmd.data_end   = last;
            end
        end else if (frag_body) begin
            push_cmd.hdr         = chunk_open;
            push_cmd.fu          = chunk_open;
            push_cmd.hdr_marker  = is_end && marker_next;
            push_cmd.fu_pos      = chunk_first ? FU_POS_START :
                                   (is_end ? FU_POS_END : FU_POS_MID);
            push_cmd.data_en     = 1'b1;
            push_cmd.data_end    = chunk_ends;
            push_cmd.tail        = last && !end_open_new;
            push_cmd.tail_marker = marker_next;
        end

        push = accept && (push_cmd.hdr || push_cmd.data_en || push_cmd.tail);

        pos_next      = last ? '0 : pos_inc[LEN_W-1:0];
        fill_next     = frag_body ? fill_inc[FRAG_W-1:0] : fill_cur;
        end_open_next = frag_body ? end_open_new : end_open_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            frag_reg     <= 1'b0;
            fill_reg     <= '0;
            end_open_reg <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            frag_reg     <= frag_next;
            fill_reg     <= fill_next;
            end_open_reg <= end_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            marker_reg <= marker_next;
            ts_reg     <= ts_next;
        end
    end

endmodule

@@ design/hrp_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module hrp_fifo import hrp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       head,
    output fifo_stat_t stat
);

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_DEPTH[FIFO_AW:0]);
    assign stat.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + {{FIFO_AW{1'b0}}, 1'b1};
        end else if (pop && !push) begin
            count_next = count_reg - {{FIFO_AW{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + {{(FIFO_AW-1){1'b0}}, 1'b1};
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + {{(FIFO_AW-1){1'b0}}, 1'b1};
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/hrp_back.sv @@
// Back end: expands each command into RTP/FU header bytes and payload bytes.
`timescale 1ns / 1ps

module hrp_back import hrp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              head,
    input  fifo_stat_t        fifo_stat,
    output logic              pop,
    input  logic [SSRC_W-1:0] ssrc_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast    // packet_end
);

    phase_t            phase_reg, phase_next;
    phase_t            cur_phase;
    phase_t            after_phase;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  seq_plus;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;

    logic              load;
    logic [7:0]        byte_out;
    logic              end_out;
    logic              seg_last;
    logic              hdr_marker;
    logic              in_hdr;
    logic [1:0]        fu_bits;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign seq_plus = seq_reg + {{(SEQ_W-1){1'b0}}, 1'b1};
    assign load     = !fifo_stat.empty && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (phase_reg == PH_START) begin
            cur_phase = head.hdr ? PH_HDR : (head.data_en ? PH_DATA :
                        (head.tail ? PH_THDR : PH_DATA));
        end else begin
            cur_phase = phase_reg;
        end

        unique case (head.fu_pos)
            FU_POS_START: fu_bits = FU_START_BITS;
            FU_POS_END:   fu_bits = FU_END_BITS;
            default:      fu_bits = 2'b00;
        endcase

        in_hdr     = (cur_phase == PH_HDR) || (cur_phase == PH_THDR);
        hdr_marker = (cur_phase == PH_THDR) ? head.tail_marker : head.hdr_marker;
        byte_out   = '0;
        end_out    = 1'b0;
        seg_last   = 1'b0;
        after_phase = PH_START;

        unique case (cur_phase)
            PH_HDR, PH_THDR: begin
                unique case (idx_reg)
                    4'd0:    byte_out = RTP_VER_BYTE;
                    4'd1:    byte_out = {hdr_marker, RTP_PT};
                    4'd2:    byte_out = seq_plus[15:8];
                    4'd3:    byte_out = seq_plus[7:0];
                    4'd4:    byte_out = head.timestamp[31:24];
                    4'd5:    byte_out = head.timestamp[23:16];
                    4'd6:    byte_out = head.timestamp[15:8];
                    4'd7:    byte_out = head.timestamp[7:0];
                    4'd8:    byte_out = ssrc_value[31:24];
                    4'd9:    byte_out = ssrc_value[23:16];
                    4'd10:   byte_out = ssrc_value[15:8];
                    4'd11:   byte_out = ssrc_value[7:0];
                    default: byte_out = '0;
                endcase
                seg_last = (idx_reg == HDR_LAST_IDX);
                if (cur_phase == PH_HDR) begin
                    end_out     = seg_last && head.hdr_end;
                    after_phase = head.fu ? PH_FU : (head.data_en ? PH_DATA :
                                  (head.tail ? PH_THDR : PH_START));
                end else begin
                    after_phase = PH_TFU;
                end
            end
            PH_FU, PH_TFU: begin
                unique case (idx_reg)
                    4'd0:    byte_out = FU_IND_HI;
                    4'd1:    byte_out = FU_IND_LO;
                    default: byte_out = (cur_phase == PH_TFU) ?
                                        {FU_END_BITS, head.kind} : {fu_bits, head.kind};
                endcase
                seg_last = (idx_reg == FU_LAST_IDX);
                if (cur_phase == PH_FU) begin
                    after_phase = head.data_en ? PH_DATA :
                                  (head.tail ? PH_THDR : PH_START);
                end else begin
                    end_out     = seg_last;
                    after_phase = PH_START;
                end
            end
            PH_DATA: begin
                byte_out    = head.data_byte;
                end_out     = head.data_end;
                seg_last    = 1'b1;
                after_phase = head.tail ? PH_THDR : PH_START;
            end
            default: begin
                byte_out    = '0;
                seg_last    = 1'b1;
                after_phase = PH_START;
            end
        endcase

        phase_next = seg_last ? after_phase : cur_phase;
        idx_next   = seg_last ? '0 : idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
        pop        = load && seg_last && (after_phase == PH_START);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            idx_reg      <= '0;
            seq_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                m_tvalid_reg <= 1'b1;
                if (in_hdr && seg_last) begin
                    seq_reg <= seq_plus;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= byte_out;
            m_tlast_reg <= end_out;
        end
    end

endmodule

@@ design/hevc_rtp_packetizer_top.sv @@
// Path: an accepted byte's command is written to the queue, and its first result is then registered on m_tdata.
// Throughput: one input item and one output item per cycle while payload flows and m_tready
// is high; each packet adds 12 (single) or 15 (fragment) header bytes on the output port, and
// the four-entry command queue throttles s_tready while those bytes drain.
// Reset: synchronous active-low aresetn clears position, sequence number, queue and
// output valid; ssrc_value returns to 0 and max_fragment to 1385.
`timescale 1ns / 1ps
`include "hevc_rtp_packetizer_top_defines.svh"

module hevc_rtp_packetizer_top import hrp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], nal_length[31:8], timestamp[63:32]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // nal_kind[5:0], frame_end[6]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte[7:0]
    output logic                  m_tlast,   // packet_end
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SSRC_W-1:0] ssrc_reg;
    logic [FRAG_W-1:0] max_frag_reg;

    logic       fifo_push;
    logic       fifo_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    fifo_stat_t fifo_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ssrc_reg     <= '0;
            max_frag_reg <= FRAG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SSRC:    ssrc_reg     <= cfg_wdata[SSRC_W-1:0];
                CFG_MAXFRAG: max_frag_reg <= cfg_wdata[FRAG_W-1:0];
                default:     ;
            endcase
        end
    end

    hrp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .max_fragment (max_frag_reg),
        .fifo_stat    (fifo_stat),
        .push         (fifo_push),
        .push_cmd     (push_cmd)
    );

    hrp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head     (head_cmd),
        .stat     (fifo_stat)
    );

    hrp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head_cmd),
        .fifo_stat  (fifo_stat),
        .pop        (fifo_pop),
        .ssrc_value (ssrc_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `HRP_ASSERT_IMPLIES(a_no_overflow, fifo_push, !fifo_stat.full, "push into full queue")
    `HRP_ASSERT_IMPLIES(a_no_underflow, fifo_pop, !fifo_stat.empty, "pop from empty queue")
    `HRP_ASSERT_NEXT(a_flag_consistent, fifo_stat.full, !fifo_stat.empty || !fifo_stat.full, "queue flags conflict")
    `HRP_ASSERT_IMPLIES(a_out_after_reset, $past(!aresetn), !m_tvalid, "output valid right after reset")

endmodule

@@ tb/hevc_rtp_packetizer_top_tb.sv @@
// Self-checking testbench for the HEVC RTP packetizer: NAL byte stream in, RTP packets out.
`timescale 1ns / 1ps

module hevc_rtp_packetizer_top_tb;
    import hrp_pkg::*;

    localparam logic [1:0] FU_MID_BITS = 2'b00;

    typedef struct packed {
        logic [7:0]  data;
        logic [23:0] len;
        logic [31:0] ts;
        logic [5:0]  kind;
        logic        fe;
    } nal_item_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       pkt_end;
    } pkt_byte_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    hevc_rtp_packetizer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    nal_item_t   pending_q[$];
    pkt_byte_t   expect_q[$];
    nal_item_t   bus_item;
    pkt_byte_t   rx_want;
    int unsigned s_gap;
    int unsigned m_stall;
    int unsigned mismatch_count;
    logic        steady_flow;

    // packetizer shadow state
    logic [31:0] ssrc_id;
    logic [10:0] frag_limit;
    logic [23:0] nal_pos;
    int unsigned held_len;
    int unsigned chunk_fill;
    logic [15:0] seq_num;
    logic        fragmenting;
    logic        end_unit_open;
    logic        nal_marker;
    logic [5:0]  cur_kind;
    logic [31:0] nal_ts;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic endp);
        pkt_byte_t pb;
        pb.byte_val = b;
        pb.pkt_end = endp;
        expect_q.push_back(pb);
    endtask

    task automatic emit_rtp_header(input logic mk, input logic ends);
        seq_num = seq_num + 16'd1;
        emit_byte(RTP_VER_BYTE, 1'b0);
        emit_byte({mk, RTP_PT}, 1'b0);
        emit_byte(seq_num[15:8], 1'b0);
        emit_byte(seq_num[7:0], 1'b0);
        for (int k = 3; k >= 0; k--)
            emit_byte(nal_ts[8*k +: 8], 1'b0);
        for (int k = 3; k >= 0; k--)
            emit_byte(ssrc_id[8*k +: 8], ends && (k == 0));
    endtask

    task automatic emit_fu_header(input logic [1:0] se, input logic ends);
        emit_byte(FU_IND_HI, 1'b0);
        emit_byte(FU_IND_LO, 1'b0);
        emit_byte({se, cur_kind}, ends);
    endtask

    // Expected packet bytes caused by one accepted NAL byte.
    task automatic packetize(input nal_item_t it);
        int unsigned mtu;
        int unsigned posn;
        logic        last;
        logic        first;
        logic        is_end;
        logic        ends;
        mtu = 32'((frag_limit < FRAG_MIN) ? FRAG_MIN : frag_limit);
        posn = 32'(nal_pos);
        if (posn == 0) begin
            held_len = (it.len == 24'd0) ? 1 : 32'(it.len);
            cur_kind = it.kind;
            nal_marker = it.fe;
            nal_ts = it.ts;
            fragmenting = (held_len > 4) && (held_len - 4 > mtu);
            chunk_fill = 0;
            end_unit_open = 1'b0;
        end
        last = (posn + 1 >= held_len);
        if (!fragmenting) begin
            if (held_len <= 4) begin
                if (last)
                    emit_rtp_header(nal_marker, 1'b1);
            end else if (posn >= 4) begin
                if (posn == 4)
                    emit_rtp_header(nal_marker, 1'b0);
                emit_byte(it.data, last);
            end
        end else if (posn >= 6) begin
            first = (posn == 6);
            if (first || chunk_fill >= mtu) begin
                is_end = !first && (held_len - posn <= mtu);
                emit_rtp_header(is_end && nal_marker, 1'b0);
                emit_fu_header(first ? FU_START_BITS : (is_end ? FU_END_BITS : FU_MID_BITS),
                               1'b0);
                chunk_fill = 0;
                end_unit_open = is_end;
            end
            ends = last || (chunk_fill + 1 >= mtu);
            emit_byte(it.data, ends);
            chunk_fill = (chunk_fill + 1) & 32'h7FF;
            if (last && !end_unit_open) begin
                emit_rtp_header(nal_marker, 1'b0);
                emit_fu_header(FU_END_BITS, 1'b1);
            end
        end
        nal_pos = last ? 24'd0 : nal_pos + 24'd1;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                packetize(bus_item);
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    bus_item = pending_q.pop_front();
                    s_tdata <= {bus_item.ts, bus_item.len, bus_item.data};
                    s_tuser <= {bus_item.fe, bus_item.kind};
                    s_tvalid <= 1'b1;
                    s_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expect_q.size() == 0) begin
                    $error("unexpected item: out_byte %h packet_end %b", m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    rx_want = expect_q.pop_front();
                    if (m_tdata !== rx_want.byte_val) begin
                        $error("out_byte: expected %h, actual %h", rx_want.byte_val, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== rx_want.pkt_end) begin
                        $error("packet_end: expected %b, actual %b", rx_want.pkt_end, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_stall = pick_gap();
            end
        end
    end

    task automatic push_noise(input int unsigned n);
        nal_item_t it;
        for (int i = 0; i < n; i++) begin
            it.data = 8'($urandom);
            it.len = 24'($urandom);
            it.ts = $urandom;
            it.kind = 6'($urandom);
            it.fe = 1'($urandom);
            pending_q.push_back(it);
        end
    endtask

    task automatic push_nal(input int unsigned n, input logic [23:0] len, input logic [5:0] kind,
                            input logic fe, input logic [31:0] ts);
        nal_item_t it;
        it.data = 8'($urandom);
        it.len = len;
        it.kind = kind;
        it.fe = fe;
        it.ts = ts;
        pending_q.push_back(it);
        push_noise(n - 1);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || expect_q.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SSRC)
            ssrc_id = val;
        else
            frag_limit = val[FRAG_W-1:0];
    endtask

    initial begin
        int unsigned len;
        int unsigned mtu_eff;
        int unsigned phase_bytes;
        int unsigned r;
        logic [31:0] mtu_cfg;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SSRC;
        cfg_wdata = '0;
        steady_flow = 1'b0;
        mismatch_count = 0;
        ssrc_id = '0;
        frag_limit = FRAG_RESET;
        nal_pos = '0;
        held_len = 0;
        chunk_fill = 0;
        seq_num = '0;
        fragmenting = 1'b0;
        end_unit_open = 1'b0;
        nal_marker = 1'b0;
        cur_kind = '0;
        nal_ts = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: short limit, tiny NALs, boundary sizes, limit change mid-NAL
        write_reg(CFG_SSRC, 32'hFFFF_FFFF);
        write_reg(CFG_MAXFRAG, 32'hFFFF_F80F);
        push_nal(1, 24'd0, 6'd0, 1'b1, 32'h0000_0000);
        push_nal(4, 24'd4, 6'd63, 1'b0, 32'hFFFF_FFFF);
        push_nal(5, 24'd5, 6'd63, 1'b1, 32'hFFFF_FFFF);
        push_nal(20, 24'd20, 6'd19, 1'b1, $urandom);
        push_nal(22, 24'd22, 6'd1, 1'b1, $urandom);
        push_nal(25, 24'd50, 6'd32, 1'b1, $urandom);
        drain();
        write_reg(CFG_MAXFRAG, 32'd20);
        push_noise(25);
        drain();
        write_reg(CFG_SSRC, 32'h0000_0000);
        write_reg(CFG_MAXFRAG, 32'd2047);
        push_nal(40, 24'd40, 6'd0, 1'b0, $urandom);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            steady_flow = (ph % 3 == 2);
            r = $urandom_range(0, 9);
            if (ph == 0)
                mtu_cfg = 32'd16;
            else if (ph == 1)
                mtu_cfg = 32'd2047;
            else if (r < 5)
                mtu_cfg = $urandom_range(16, 40);
            else if (r < 7)
                mtu_cfg = $urandom_range(0, 15);
            else if (r < 9)
                mtu_cfg = $urandom_range(41, 120);
            else
                mtu_cfg = 32'd2047;
            write_reg(CFG_MAXFRAG, mtu_cfg);
            write_reg(CFG_SSRC, $urandom);
            mtu_eff = (mtu_cfg < 16) ? 16 : mtu_cfg;
            phase_bytes = 0;
            while (phase_bytes < 20) begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    len = $urandom_range(0, 8);
                else if (r < 4 || mtu_eff > 40)
                    len = $urandom_range(5, (mtu_eff + 4 > 48) ? 48 : mtu_eff + 4);
                else
                    len = mtu_eff + 5 + $urandom_range(0, 2 * mtu_eff);
                push_nal((len == 0) ? 1 : len, 24'(len), 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)), $urandom);
                phase_bytes += (len == 0) ? 1 : len;
            end
        end
        drain();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
